>>> design/zn_lattice_link_metropolis_defines.svh
// Assertion macros for the Z_N lattice link update checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ZN_LATTICE_LINK_METROPOLIS_DEFINES_SVH
`define ZN_LATTICE_LINK_METROPOLIS_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define ZLLM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zllm check failed");

// Next-cycle implication, checked during reset too.
`define ZLLM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("zllm check failed");

`endif

>>> design/zllm_pkg.sv
// Shared types, constants and table builders for the Z_N link update.
// No dependencies.
`default_nettype none

package zllm_pkg;

    localparam int LATTICE_SIZE_DEF = 16;
    localparam int MAX_ORDER        = 16;

    localparam logic [1:0] REG_BETA  = 2'd0;
    localparam logic [1:0] REG_ORDER = 2'd1;

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [27:0] LN2_Q28   = 28'd186065280;
    localparam logic [28:0] Q28_ONE   = 29'd268435456;

    // ceil(2^31 / k) for k = 1..8, exact truncating divide for values below 2^28
    localparam logic [31:0] RECIP [8] = '{
        32'd2147483648, 32'd1073741824, 32'd715827883, 32'd536870912,
        32'd429496730,  32'd357913942,  32'd306783379, 32'd268435456
    };

    typedef struct packed {
        logic        start;
        logic [31:0] x;
    } t_boltz_req;

    typedef struct packed {
        logic        done;
        logic [16:0] prob;
    } t_boltz_rsp;

    typedef logic signed [15:0] t_cos_tab [256];

    // m mod d by restoring subtraction, m four bits
    function automatic logic [6:0] mod_small(input logic [3:0] m, input logic [6:0] d);
        logic [7:0] r;
        r = '0;
        for (int i = 3; i >= 0; i--) begin
            r = {r[6:0], m[i]};
            if (r >= {1'b0, d}) r = r - {1'b0, d};
        end
        return r[6:0];
    endfunction

    function automatic logic signed [15:0] cos_quarter(input logic [31:0] t_in);
        logic [63:0] t, th, x2, a, v;
        logic        use_sin;
        t = {32'd0, t_in};
        use_sin = (t > 64'd8192);
        if (use_sin) t = 64'd16384 - t;
        th = (t * 64'd1686629713) >> 16;
        x2 = (th * th) >> 28;
        if (!use_sin) begin
            a = 64'd6658;
            a = 64'd372827 - ((x2 * a) >> 28);
            a = 64'd11184811 - ((x2 * a) >> 28);
            a = 64'd134217728 - ((x2 * a) >> 28);
            v = 64'd268435456 - ((x2 * a) >> 28);
        end else begin
            a = 64'd740;
            a = 64'd53261 - ((x2 * a) >> 28);
            a = 64'd2236962 - ((x2 * a) >> 28);
            a = 64'd44739243 - ((x2 * a) >> 28);
            a = 64'd268435456 - ((x2 * a) >> 28);
            v = (th * a) >> 28;
        end
        v = (v + 64'd32768) >> 16;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] zn_cos(input logic [31:0] m, input logic [31:0] n);
        logic [31:0] num, q;
        logic [32:0] r;
        logic [31:0] p, rem;
        num = m * 32'd65536 + (n >> 1);
        q = '0;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            r = {r[31:0], num[i]};
            if (r >= {1'b0, n}) begin
                r = r - {1'b0, n};
                q[i] = 1'b1;
            end
        end
        p = q;
        rem = {18'd0, p[13:0]};
        case (p[15:14])
            2'd0:    return cos_quarter(rem);
            2'd1:    return -cos_quarter(32'd16384 - rem);
            2'd2:    return -cos_quarter(rem);
            default: return cos_quarter(32'd16384 - rem);
        endcase
    endfunction

    // entry {n-1, m}: cos(2*pi*m/n) in Q12
    function automatic t_cos_tab build_cos();
        t_cos_tab    tab;
        logic [31:0] m, n;
        for (int i = 0; i < 256; i++) begin
            m = i % 16;
            n = i / 16 + 1;
            if (n >= 2 && m < n) tab[i] = zn_cos(m, n);
            else tab[i] = '0;
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos();

endpackage

`default_nettype wire

>>> design/zllm_link_ram.sv
// Single-port link memory with a registered read port.
// Depends on nothing.
`default_nettype none

module zllm_link_ram #(
    parameter int DEPTH = 12288,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [3:0]    i_wdata,
    output logic      [3:0]    o_rdata
);

    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/zllm_boltz.sv
// Iterative exp(-beta*dS) unit: two scaling multiplies, eight Horner steps.
// Depends on zllm_pkg.
`default_nettype none

module zllm_boltz (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire zllm_pkg::t_boltz_req i_req,
    output zllm_pkg::t_boltz_rsp     o_rsp
);
    import zllm_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_M1, B_M2, B_HA, B_HB, B_OUT} t_bstate;

    t_bstate     r_state;
    logic [31:0] r_x;
    logic [8:0]  r_n;
    logic [23:0] r_f;
    logic [27:0] r_z;
    logic [28:0] r_h;
    logic [27:0] r_v;
    logic [2:0]  r_k;
    logic        r_done;
    logic [16:0] r_prob;

    logic [56:0] prod_y;
    logic [51:0] prod_z;
    logic [56:0] prod_v;
    logic [59:0] prod_q;
    logic [28:0] shifted;

    assign prod_y  = 57'(r_x) * 57'(LOG2E_Q24);
    assign prod_z  = 52'(r_f) * 52'(LN2_Q28);
    assign prod_v  = 57'(r_z) * 57'(r_h);
    assign prod_q  = 60'(r_v) * 60'(RECIP[r_k]);
    assign shifted = r_h >> (r_n[4:0] + 5'd12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == B_OUT);
            case (r_state)
                B_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_state <= B_M1;
                    end
                end
                B_M1: begin
                    r_n     <= prod_y[56:48];
                    r_f     <= prod_y[47:24];
                    r_state <= B_M2;
                end
                B_M2: begin
                    r_z     <= prod_z[51:24];
                    r_h     <= Q28_ONE;
                    r_k     <= 3'd7;
                    r_state <= B_HA;
                end
                B_HA: begin
                    r_v     <= prod_v[55:28];
                    r_state <= B_HB;
                end
                B_HB: begin
                    r_h <= Q28_ONE - prod_q[59:31];
                    if (r_k == 3'd0) begin
                        r_state <= B_OUT;
                    end else begin
                        r_k     <= r_k - 3'd1;
                        r_state <= B_HA;
                    end
                end
                B_OUT: begin
                    r_prob  <= (r_n >= 9'd17) ? 17'd0 : shifted[16:0];
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prob = r_prob;

endmodule

`default_nettype wire

>>> design/zn_lattice_link_metropolis.sv
// Metropolis update of one Z_N gauge link; links held in a single-port memory.
// One item is processed at a time, through 13 serial link reads, four cosine steps
// and, only when dS > 0, the Horner unit that evaluates exp(-beta*dS); a new item is
// taken only once the previous result has been handed to the output register.
// Reset: a clearing pass writes identity to all LATTICE_SIZE^3*3 links while stall
// stays high; configuration writes are taken.
// Depends on zllm_pkg, zllm_link_ram, zllm_boltz.
`default_nettype none

module zn_lattice_link_metropolis #(
    parameter int LATTICE_SIZE = zllm_pkg::LATTICE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_site_x,
    input  wire logic [3:0]  i_site_y,
    input  wire logic [3:0]  i_site_z,
    input  wire logic [1:0]  i_direction,
    input  wire logic [3:0]  i_proposal,
    input  wire logic [15:0] i_uniform,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_accepted,
    output logic signed [15:0] o_action_term,
    output logic [3:0]       o_link_value,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import zllm_pkg::*;

    localparam int CW    = (LATTICE_SIZE > 1) ? $clog2(LATTICE_SIZE) : 1;
    localparam int DEPTH = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE * 3;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] L_A = AW'(LATTICE_SIZE);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_STAPLE, S_COS, S_DEC, S_BOLTZ, S_WRITE
    } t_state;

    typedef logic [2:0][CW-1:0] t_crd;

    // step a coordinate one place along an axis, wrapping at the lattice edge
    function automatic t_crd move(input t_crd c, input logic [1:0] axis, input logic up);
        t_crd o;
        o = c;
        for (int a = 0; a < 3; a++) begin
            if (axis == 2'(a)) begin
                if (up) o[a] = (c[a] == CW'(LATTICE_SIZE - 1)) ? '0 : c[a] + 1'b1;
                else    o[a] = (c[a] == '0) ? CW'(LATTICE_SIZE - 1) : c[a] - 1'b1;
            end
        end
        return o;
    endfunction

    function automatic logic [AW-1:0] addr_of(input t_crd c, input logic [1:0] dir);
        return ((AW'(c[0]) * L_A + AW'(c[1])) * L_A + AW'(c[2])) * AW'(3) + AW'(dir);
    endfunction

    // reduce a staple sum below 3n to the range 0..n-1
    function automatic logic [3:0] stp_mod(input logic [6:0] t, input logic [4:0] n);
        logic [6:0] r;
        r = t;
        if (r >= {1'b0, n, 1'b0}) r = r - {1'b0, n, 1'b0};
        else if (r >= {2'b0, n}) r = r - {2'b0, n};
        return r[3:0];
    endfunction

    // configuration
    logic [15:0] r_beta;
    logic [4:0]  r_gorder;
    logic [4:0]  n_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta   <= '0;
            r_gorder <= 5'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BETA:  r_beta   <= i_cfg_data;
                REG_ORDER: r_gorder <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ord = r_gorder;
        if (n_ord < 5'd2) n_ord = 5'd2;
        if (n_ord > 5'(MAX_ORDER)) n_ord = 5'(MAX_ORDER);
    end

    // control and payload
    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic [3:0]      r_cnt;
    t_crd            r_c;
    logic [1:0]      r_d;
    logic [3:0]      r_unew;
    logic [15:0]     r_uni;
    logic [AW-1:0]   r_addr0;
    logic            r_rd_vld;
    logic [3:0]      r_rd_idx;
    logic [3:0]      r_lnk [13];
    logic [3:0]      r_stp [4];
    logic signed [15:0] r_sum_old, r_sum_new;
    logic            r_acc;
    logic            r_out_valid;
    logic            r_out_acc;
    logic signed [15:0] r_out_act;
    logic [3:0]      r_out_link;
    t_boltz_req      r_breq;
    t_boltz_rsp      boltz_rsp;

    logic            in_take;
    logic            out_free;
    logic [1:0]      dp0, dp1, dpx;
    logic [3:0]      rr;
    t_crd            xd, xp, xm, xdm, rd_c;
    logic [1:0]      rd_dir;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [3:0]      mem_rdata;
    logic [4:0]      ph_old, ph_new;
    logic [3:0]      ph_old_r, ph_new_r;
    logic signed [16:0] ds;
    logic [6:0]      mx, my, mz, mp, ml;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // neighbor link addressing: the link itself, then six links per other axis
    assign dp0 = (r_d == 2'd0) ? 2'd1 : 2'd0;
    assign dp1 = (r_d == 2'd2) ? 2'd1 : 2'd2;
    assign dpx = (r_cnt < 4'd7) ? dp0 : dp1;
    assign rr  = (r_cnt < 4'd7) ? r_cnt - 4'd1 : r_cnt - 4'd7;
    assign xd  = move(r_c, r_d, 1'b1);
    assign xp  = move(r_c, dpx, 1'b1);
    assign xm  = move(r_c, dpx, 1'b0);
    assign xdm = move(xm, r_d, 1'b1);

    always_comb begin
        rd_c   = r_c;
        rd_dir = r_d;
        if (r_cnt != 4'd0) begin
            case (rr)
                4'd0: begin rd_c = xd;  rd_dir = dpx; end
                4'd1: begin rd_c = xp;  rd_dir = r_d; end
                4'd2: begin rd_c = r_c; rd_dir = dpx; end
                4'd3: begin rd_c = xdm; rd_dir = dpx; end
                4'd4: begin rd_c = xm;  rd_dir = r_d; end
                default: begin rd_c = xm; rd_dir = dpx; end
            endcase
        end
    end
    assign rd_addr = addr_of(rd_c, rd_dir);

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = rd_addr;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            S_WRITE: begin
                mem_we   = out_free && r_acc;
                mem_addr = r_addr0;
            end
            default: ;
        endcase
    end

    zllm_link_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata((r_state == S_CLEAR) ? 4'd0 : r_unew),
        .o_rdata(mem_rdata)
    );

    zllm_boltz u_boltz (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_breq),
        .o_rsp  (boltz_rsp)
    );

    // phases of staple times old and new link
    assign ph_old   = {1'b0, r_stp[r_cnt[1:0]]} + {1'b0, r_lnk[0]};
    assign ph_new   = {1'b0, r_stp[r_cnt[1:0]]} + {1'b0, r_unew};
    assign ph_old_r = 4'((ph_old >= n_ord) ? ph_old - n_ord : ph_old);
    assign ph_new_r = 4'((ph_new >= n_ord) ? ph_new - n_ord : ph_new);
    assign ds       = {r_sum_old[15], r_sum_old} - {r_sum_new[15], r_sum_new};

    assign mx = mod_small(i_site_x, 7'(LATTICE_SIZE));
    assign my = mod_small(i_site_y, 7'(LATTICE_SIZE));
    assign mz = mod_small(i_site_z, 7'(LATTICE_SIZE));
    assign mp = mod_small(i_proposal, {2'b0, n_ord});
    assign ml = mod_small(mem_rdata, {2'b0, n_ord});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_take) n_state = S_READ;
            S_READ:   if (r_cnt == 4'd13) n_state = S_STAPLE;
            S_STAPLE: n_state = S_COS;
            S_COS:    if (r_cnt == 4'd3) n_state = S_DEC;
            S_DEC:    n_state = (ds <= 17'sd0) ? S_WRITE : S_BOLTZ;
            S_BOLTZ:  if (boltz_rsp.done) n_state = S_WRITE;
            S_WRITE:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_breq      <= '0;
        end else begin
            r_state      <= n_state;
            // launch the Horner unit only when the action rises
            r_breq.start <= (r_state == S_DEC) && !(ds <= 17'sd0);
            r_rd_vld     <= (r_state == S_READ) && (r_cnt != 4'd13);
            r_rd_idx     <= r_cnt;
            if (r_out_valid && !i_stall && (r_state != S_WRITE)) r_out_valid <= 1'b0;

            // hold captured link values reduced modulo the current order
            if (r_rd_vld) r_lnk[r_rd_idx] <= ml[3:0];

            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (in_take) begin
                        r_c[0] <= mx[CW-1:0];
                        r_c[1] <= my[CW-1:0];
                        r_c[2] <= mz[CW-1:0];
                        r_d    <= (i_direction == 2'd3) ? 2'd2 : i_direction;
                        r_unew <= mp[3:0];
                        r_uni  <= i_uniform;
                        r_cnt  <= '0;
                    end
                end
                S_READ: begin
                    if (r_cnt == 4'd0) r_addr0 <= rd_addr;
                    r_cnt <= r_cnt + 4'd1;
                end
                S_STAPLE: begin
                    r_stp[0] <= stp_mod({3'b0, r_lnk[1]} + {1'b0, n_ord, 1'b0}
                                        - {3'b0, r_lnk[2]} - {3'b0, r_lnk[3]}, n_ord);
                    r_stp[1] <= stp_mod({3'b0, r_lnk[6]} + {1'b0, n_ord, 1'b0}
                                        - {3'b0, r_lnk[4]} - {3'b0, r_lnk[5]}, n_ord);
                    r_stp[2] <= stp_mod({3'b0, r_lnk[7]} + {1'b0, n_ord, 1'b0}
                                        - {3'b0, r_lnk[8]} - {3'b0, r_lnk[9]}, n_ord);
                    r_stp[3] <= stp_mod({3'b0, r_lnk[12]} + {1'b0, n_ord, 1'b0}
                                        - {3'b0, r_lnk[10]} - {3'b0, r_lnk[11]}, n_ord);
                    r_sum_old <= '0;
                    r_sum_new <= '0;
                    r_cnt     <= '0;
                end
                S_COS: begin
                    // accumulate one staple per cycle for both candidates
                    r_sum_old <= r_sum_old + COS_TAB[{4'(n_ord - 5'd1), ph_old_r}];
                    r_sum_new <= r_sum_new + COS_TAB[{4'(n_ord - 5'd1), ph_new_r}];
                    r_cnt     <= r_cnt + 4'd1;
                end
                S_DEC: begin
                    if (ds <= 17'sd0) begin
                        r_acc <= 1'b1;
                    end else begin
                        r_breq.x <= 32'(r_beta) * 32'(ds[15:0]);
                    end
                end
                S_BOLTZ: begin
                    if (boltz_rsp.done) r_acc <= ({1'b0, r_uni} < boltz_rsp.prob);
                end
                S_WRITE: begin
                    // drop the result into the output register once it is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= r_acc;
                        r_out_act   <= r_acc ? r_sum_new : r_sum_old;
                        r_out_link  <= r_acc ? r_unew : r_lnk[0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_action_term = r_out_act;
    assign o_link_value  = r_out_link;

endmodule

`default_nettype wire

>>> design/zllm_checker.sv
// Port-level checks for the Z_N link update block, bound to the top level.
// Depends on zn_lattice_link_metropolis_defines.svh.
`default_nettype none
`include "zn_lattice_link_metropolis_defines.svh"

module zllm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_action_term,
    input wire logic [3:0]  o_link_value
);

    `ZLLM_ASSERT_NXT(a_rst_no_out, !i_rst_n, !o_valid && o_stall)
    `ZLLM_ASSERT_NXT(a_busy_after_take, i_rst_n && i_valid && !o_stall, !i_rst_n || o_stall)
    `ZLLM_ASSERT_IMP(a_term_range, o_valid,
        $signed(o_action_term) >= -16384 && $signed(o_action_term) <= 16384)
    `ZLLM_ASSERT_IMP(a_out_hold, $past(o_valid && i_stall && i_rst_n),
        o_valid && $stable(o_link_value) && $stable(o_action_term))

endmodule

bind zn_lattice_link_metropolis zllm_checker u_zllm_checker (.*);

`default_nettype wire
